@@ rtl/sdrx_pkg.sv @@
package sdrx_pkg;

  localparam int BLOCK_BYTES = 5;
  localparam int BLOCK_W = 8 * BLOCK_BYTES;
  localparam int READ_MAX = 4;

  localparam logic [1:0] MODE_TRIPLE = 2'd0;
  localparam logic [1:0] MODE_READ = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] SMODE_RAW = 2'd1;
  localparam logic [1:0] SMODE_TEXT = 2'd2;

  localparam logic [4:0] SYNC_FRAME = 5'd21;
  localparam logic [3:0] HDR_TYPE_TEXT = 4'h3;
  localparam logic [3:0] HDR_TYPE_MSG = 4'h4;
  localparam logic [3:0] TEXT_LEN_LIMIT = 4'd6;
  localparam logic [3:0] TEXT_FIRST_MAX = 4'd3;

  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_STREAM_MODE = 3'd0;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [4:0] frame_count;
  } sdrx_item_t;

  typedef struct packed {
    logic [7:0] sb0;
    logic [7:0] sb1;
    logic [7:0] sb2;
    logic [1:0] cnt;
    logic [3:0] mask;
    logic complete;
    logic is_read;
    logic [1:0] nres_m1;
    logic [READ_MAX-1:0][BLOCK_W-1:0] blk;
  } sdrx_res_t;

endpackage

@@ rtl/slow_data_rx_deframer_core.sv @@
// Slow-data receive deframer. Each input beat is a slow-data triple with its
// frame number, a read-message command or a clear-mask command. Triples and
// clears give one output beat; a read gives one beat per message block (up to
// four), each carrying five characters, with last on the final one. A beat is
// taken every cycle: one input register, then combinational decode into a
// result register, and the input stalls only while a read's multi-beat
// result is still draining or the output is stalled.
// stream_mode (address 0) selects raw triple or text-block forwarding.
module slow_data_rx_deframer_core
  import sdrx_pkg::*;
#(
  parameter int MESSAGE_BLOCKS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            mode,
  input  logic [7:0]            byte0,
  input  logic [7:0]            byte1,
  input  logic [7:0]            byte2,
  input  logic [4:0]            frame_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            stream_byte0,
  output logic [7:0]            stream_byte1,
  output logic [7:0]            stream_byte2,
  output logic [1:0]            stream_count,
  output logic [3:0]            received_mask,
  output logic                  message_complete,
  output logic [39:0]           message_block,
  output logic [1:0]            block_number,
  output logic                  last
);

  logic [1:0] stream_mode;
  sdrx_item_t item;
  logic       item_valid;
  logic       free;
  logic       adv;
  sdrx_res_t  res;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_STREAM_MODE) ? 32'(stream_mode) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_mode <= '0;
    end else if (psel && penable && pwrite && paddr == ADDR_STREAM_MODE) begin
      stream_mode <= pwdata[1:0];
    end
  end

  assign adv = item_valid && free;
  assign in_stall = item_valid && !free;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (adv) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= '{mode: mode, byte0: byte0, byte1: byte1, byte2: byte2,
                frame_count: frame_count};
    end
  end

  sdrx_core #(
    .MESSAGE_BLOCKS(MESSAGE_BLOCKS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .stream_mode(stream_mode),
    .go         (adv),
    .item       (item),
    .res        (res)
  );

  sdrx_out u_out (
    .clk             (clk),
    .rst             (rst),
    .load            (adv),
    .res_in          (res),
    .free            (free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .stream_byte0    (stream_byte0),
    .stream_byte1    (stream_byte1),
    .stream_byte2    (stream_byte2),
    .stream_count    (stream_count),
    .received_mask   (received_mask),
    .message_complete(message_complete),
    .message_block   (message_block),
    .block_number    (block_number),
    .last            (last)
  );

endmodule

@@ rtl/sdrx_core.sv @@
module sdrx_core
  import sdrx_pkg::*;
#(
  parameter int MESSAGE_BLOCKS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] stream_mode,
  input  logic       go,
  input  sdrx_item_t item,
  output sdrx_res_t  res
);

  localparam int NRES = (MESSAGE_BLOCKS < READ_MAX) ? MESSAGE_BLOCKS : READ_MAX;
  localparam logic [3:0] NUM_BLOCKS = 4'(MESSAGE_BLOCKS);

  logic [MESSAGE_BLOCKS-1:0][BLOCK_W-1:0] row;
  logic [MESSAGE_BLOCKS-1:0] mask;
  logic [MESSAGE_BLOCKS-1:0] mask_next;
  logic [7:0] held_header;
  logic [7:0] held_header_next;
  logic [1:0] spl;
  logic [1:0] spl_next;

  logic       active;
  logic       odd;
  logic [7:0] hdr;
  logic       msg_hit;
  logic       wr_first;
  logic       wr_second;
  logic [7:0] mask8;
  logic [READ_MAX-1:0][BLOCK_W-1:0] rd_blk;

  for (genvar i = 0; i < READ_MAX; i++) begin : g_rd
    if (i < MESSAGE_BLOCKS) begin : g_row
      assign rd_blk[i] = row[i];
    end else begin : g_zero
      assign rd_blk[i] = '0;
    end
  end

  assign active = (item.mode == MODE_TRIPLE) && (item.frame_count != SYNC_FRAME);
  assign odd = item.frame_count[0];
  assign hdr = odd ? item.byte0 : held_header;
  assign msg_hit = (hdr[7:4] == HDR_TYPE_MSG) && (hdr[3:0] < NUM_BLOCKS);
  assign wr_first = go && active && odd && msg_hit;
  assign wr_second = go && active && !odd && msg_hit;

  always_comb begin
    logic [3:0] len;
    len = item.byte0[3:0];
    res = '0;
    mask_next = mask;
    held_header_next = held_header;
    spl_next = spl;
    res.nres_m1 = 2'(NRES - 1);
    res.blk = rd_blk;
    unique case (item.mode)
      MODE_TRIPLE: begin
        if (active) begin
          if (odd) begin
            held_header_next = item.byte0;
          end
          if (!odd && msg_hit) begin
            mask_next = mask | (MESSAGE_BLOCKS'(1) << hdr[3:0]);
          end
          if (stream_mode == SMODE_RAW) begin
            res.sb0 = item.byte0;
            res.sb1 = item.byte1;
            res.sb2 = item.byte2;
            res.cnt = 2'd3;
          end else if (stream_mode == SMODE_TEXT) begin
            if (odd) begin
              spl_next = '0;
              if (item.byte0[7:4] == HDR_TYPE_TEXT && len < TEXT_LEN_LIMIT) begin
                if (len < TEXT_FIRST_MAX) begin
                  res.cnt = len[1:0];
                end else begin
                  res.cnt = 2'd2;
                  spl_next = 2'(len - 4'd2);
                end
                res.sb0 = (res.cnt >= 2'd1) ? item.byte1 : '0;
                res.sb1 = (res.cnt >= 2'd2) ? item.byte2 : '0;
              end
            end else if (spl != 2'd0) begin
              res.cnt = spl;
              res.sb0 = item.byte0;
              res.sb1 = (spl >= 2'd2) ? item.byte1 : '0;
              res.sb2 = (spl == 2'd3) ? item.byte2 : '0;
            end
          end
        end
      end
      MODE_READ: begin
        res.is_read = 1'b1;
        mask_next = '0;
      end
      MODE_CLEAR: begin
        mask_next = '0;
      end
      default: begin
      end
    endcase
    mask8 = 8'(item.mode == MODE_READ ? mask : mask_next);
    res.mask = mask8[3:0];
    res.complete = (item.mode == MODE_READ) ? (&mask) : (&mask_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
      held_header <= '0;
      spl <= '0;
      row <= '0;
    end else begin
      if (go) begin
        mask <= mask_next;
        held_header <= held_header_next;
        spl <= spl_next;
      end
      for (int r = 0; r < MESSAGE_BLOCKS; r++) begin
        if (wr_first && hdr[3:0] == 4'(r)) begin
          row[r][39:24] <= {item.byte1, item.byte2};
        end
        if (wr_second && hdr[3:0] == 4'(r)) begin
          row[r][23:0] <= {item.byte0, item.byte1, item.byte2};
        end
      end
    end
  end

endmodule

@@ rtl/sdrx_out.sv @@
module sdrx_out
  import sdrx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  sdrx_res_t   res_in,
  output logic        free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  stream_byte0,
  output logic [7:0]  stream_byte1,
  output logic [7:0]  stream_byte2,
  output logic [1:0]  stream_count,
  output logic [3:0]  received_mask,
  output logic        message_complete,
  output logic [39:0] message_block,
  output logic [1:0]  block_number,
  output logic        last
);

  sdrx_res_t  res;
  logic       res_valid;
  logic [1:0] idx;
  logic       beat;

  assign out_valid = res_valid;
  assign beat = res_valid && !out_stall;
  assign last = !res.is_read || (idx == res.nres_m1);
  assign free = !res_valid || (beat && last);

  assign stream_byte0 = res.sb0;
  assign stream_byte1 = res.sb1;
  assign stream_byte2 = res.sb2;
  assign stream_count = res.cnt;
  assign received_mask = res.mask;
  assign message_complete = res.complete;
  assign message_block = res.is_read ? res.blk[idx] : '0;
  assign block_number = res.is_read ? idx : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx <= '0;
    end else if (load) begin
      res_valid <= 1'b1;
      idx <= '0;
    end else if (beat) begin
      if (last) begin
        res_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule
